### rtl/ckc_pkg.sv
// ckc_pkg: shared types and constants for the canonical k-mer counter.
// No dependencies; imported by every module of the block but ckc_queue.
`default_nettype none

package ckc_pkg;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // width of the k-mer size register
    localparam int KSIZE_W = 4;
    // reset value of the k-mer size register (before clamping to MAX_K)
    localparam int KSIZE_RESET = 8;
    // valid-run counter saturates here
    localparam logic [3:0] RUN_MAX = 4'd15;

    typedef struct packed {
        logic       func;
        logic [7:0] base_char;
        logic       seq_start;
    } kmer_item_t;

    typedef struct packed {
        logic [31:0] position;
        logic [15:0] forward_word;
        logic [15:0] reverse_word;
        logic        kmer_valid;
        logic [31:0] occurrences;
    } kmer_result_t;

    // table operation handed from front to back
    typedef struct packed {
        logic        is_query;
        logic        kmer_valid;
        logic [31:0] position;
        logic [15:0] forward_word;
        logic [15:0] reverse_word;
    } kmer_op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

`default_nettype wire

### rtl/ckc_front.sv
// ckc_front: accepts bases, maintains the forward/reverse windows and run
// counters, and emits table operations. Depends on ckc_pkg.
`default_nettype none

module ckc_front
    import ckc_pkg::*;
#(
    parameter int MAX_K    = 8,
    parameter int POS_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [KSIZE_W-1:0]     cfg_data,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire kmer_item_t             in_data,
    input  wire logic                   table_ready,
    input  wire logic                   q_full,
    output      logic                   op_push,
    output      kmer_op_t               op_data,
    output      logic [2*MAX_K-1:0]     op_canon
);

    localparam int WIN_W = 2 * MAX_K;
    localparam logic [KSIZE_W-1:0] K_MAX = KSIZE_W'(MAX_K);
    localparam logic [KSIZE_W-1:0] K_RESET =
        KSIZE_W'((MAX_K < KSIZE_RESET) ? MAX_K : KSIZE_RESET);
    localparam logic [31:0] POS_MAX = 32'((64'd1 << POS_BITS) - 64'd1);

    logic [KSIZE_W-1:0] k_reg;
    logic [WIN_W-1:0]   fwd_reg, fwd_next;
    logic [WIN_W-1:0]   rev_reg, rev_next;
    logic [31:0]        seen_reg, seen_next;
    logic [3:0]         run_reg, run_next;

    logic               accept;
    logic [1:0]         code;
    logic               good;
    logic [WIN_W-1:0]   fwd_base, rev_base, mask, comp_ins;
    logic [KSIZE_W:0]   k2;
    logic               full, kvalid;
    logic [31:0]        pos_raw;
    logic [WIN_W+15:0]  fwd_ext, rev_ext;

    assign in_ready = table_ready && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        good = 1'b1;
        case (in_data.base_char)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default:
            begin
                code = CODE_A;
                good = 1'b0;
            end
        endcase
    end

    assign k2 = {k_reg, 1'b0};

    always_comb
    begin
        for (int i = 0; i < WIN_W; i++)
        begin
            mask[i] = ((KSIZE_W + 1)'(i) < k2);
        end
        comp_ins = '0;
        // complement of the new base goes in at the top of the k-base window
        for (int i = 0; i < MAX_K; i++)
        begin
            if (KSIZE_W'(i + 1) == k_reg)
            begin
                comp_ins[2*i +: 2] = CODE_T - code;
            end
        end
    end

    always_comb
    begin
        fwd_base  = in_data.seq_start ? '0 : fwd_reg;
        rev_base  = in_data.seq_start ? '0 : rev_reg;
        seen_next = in_data.seq_start ? 32'd0 : seen_reg;
        run_next  = in_data.seq_start ? 4'd0 : run_reg;

        fwd_next = ((fwd_base << 2) | WIN_W'(code)) & mask;
        rev_next = (((rev_base & mask) >> 2) | comp_ins) & mask;

        if (seen_next != 32'hFFFF_FFFF)
        begin
            seen_next = seen_next + 32'd1;
        end
        if (!good)
        begin
            run_next = 4'd0;
        end
        else if (run_next != RUN_MAX)
        begin
            run_next = run_next + 4'd1;
        end
    end

    assign full    = seen_next >= 32'(k_reg);
    assign kvalid  = run_next >= 4'(k_reg);
    assign pos_raw = seen_next - 32'(k_reg) + 32'd1;
    assign fwd_ext = {16'd0, fwd_next};
    assign rev_ext = {16'd0, rev_next};

    always_comb
    begin
        op_data.is_query     = in_data.func == FUNC_QUERY;
        op_data.kmer_valid   = kvalid;
        op_data.position     = (pos_raw > POS_MAX) ? POS_MAX : pos_raw;
        op_data.forward_word = fwd_ext[15:0];
        op_data.reverse_word = rev_ext[15:0];
        op_canon             = (fwd_next < rev_next) ? fwd_next : rev_next;
        // counting beats with an invalid window never touch the table
        op_push = accept && full && (op_data.is_query || kvalid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= K_RESET;
            fwd_reg  <= '0;
            rev_reg  <= '0;
            seen_reg <= '0;
            run_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_data == '0)
                    k_reg <= KSIZE_W'(1);
                else if (cfg_data > K_MAX)
                    k_reg <= K_MAX;
                else
                    k_reg <= cfg_data;
            end
            if (accept)
            begin
                fwd_reg  <= fwd_next;
                rev_reg  <= rev_next;
                seen_reg <= seen_next;
                run_reg  <= run_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ckc_queue.sv
// ckc_queue: small register FIFO decoupling front and back.
// Depends on nothing but its parameters.
`default_nettype none

module ckc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output      logic              full,
    input  wire logic              pop,
    output      logic              valid,
    output      logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign valid    = cnt_reg != '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/ckc_back.sv
// ckc_back: count table memory with clearing pass, read-modify-write for
// counting and lookup plus output register for queries. Depends on ckc_pkg.
`default_nettype none

module ckc_back
    import ckc_pkg::*;
#(
    parameter int MAX_K      = 8,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    output      logic               table_ready,
    input  wire logic               q_valid,
    output      logic               q_pop,
    input  wire kmer_op_t           q_op,
    input  wire logic [2*MAX_K-1:0] q_canon,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      kmer_result_t       out_data
);

    localparam int ADDR_W = 2 * MAX_K;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;

    back_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    kmer_op_t              op_reg, op_next;
    logic [ADDR_W-1:0]     canon_reg, canon_next;
    logic                  out_valid_reg, out_valid_next;
    kmer_result_t          out_reg, out_next;

    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  out_free;

    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_reg;
    assign table_ready = state_reg != BK_CLEAR;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        canon_next     = canon_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = canon_reg;
        wr_data        = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
        rd_en          = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            BK_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    op_next    = q_op;
                    canon_next = q_canon;
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (op_reg.is_query)
                begin
                    if (out_free)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.position     = op_reg.position;
                        out_next.forward_word = op_reg.forward_word;
                        out_next.reverse_word = op_reg.reverse_word;
                        out_next.kmer_valid   = op_reg.kmer_valid;
                        out_next.occurrences  = op_reg.kmer_valid ?
                                                32'(rd_data_reg) : 32'd0;
                        state_next            = BK_IDLE;
                    end
                end
                else
                begin
                    // counting beat: write back the saturated increment
                    wr_en      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[q_canon];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        canon_reg <= canon_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/canonical_kmer_counter.sv
// Canonical k-mer counter: front (windows), op queue, back (count table).
// Front takes one base per cycle unless the op queue is full or the table is clearing.
// Each table operation passes the back as a read, then a write or a result, and the
// next is popped only after; a query result waits for the output register to free.
// After reset all 4**MAX_K table entries are cleared; in_ready stays low meanwhile.
// Configuration writes are taken every cycle. Depends on ckc_pkg and submodules.
`default_nettype none

module canonical_kmer_counter
    import ckc_pkg::*;
#(
    parameter int MAX_K      = 8,
    parameter int COUNT_BITS = 32,
    parameter int POS_BITS   = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [KSIZE_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire kmer_item_t         in_data,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      kmer_result_t       out_data
);

    localparam int ADDR_W = 2 * MAX_K;
    localparam int OP_W   = $bits(kmer_op_t) + ADDR_W;

    logic               table_ready;
    logic               q_full, q_valid, q_pop, op_push;
    kmer_op_t           op_data, q_op;
    logic [ADDR_W-1:0]  op_canon, q_canon;
    logic [OP_W-1:0]    q_pop_data;

    assign cfg_ready = 1'b1;

    ckc_front #(
        .MAX_K    (MAX_K),
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .table_ready (table_ready),
        .q_full      (q_full),
        .op_push     (op_push),
        .op_data     (op_data),
        .op_canon    (op_canon)
    );

    ckc_queue #(
        .DATA_W (OP_W),
        .DEPTH  (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data ({op_data, op_canon}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    assign q_op    = q_pop_data[OP_W-1:ADDR_W];
    assign q_canon = q_pop_data[ADDR_W-1:0];

    ckc_back #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_ready (table_ready),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_op        (q_op),
        .q_canon     (q_canon),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

### bench/canonical_kmer_counter_test.sv
// Testbench for canonical_kmer_counter: directed and random base streams, self-checking.
// Depends on ckc_pkg and the canonical_kmer_counter RTL; keeps its own window/table model.
`timescale 1ns / 100ps

module canonical_kmer_counter_test;
    import ckc_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 27;
    localparam int MODEL_MAX_K   = 8;
    localparam int STRAND_MAX    = 64;

    localparam logic [7:0] DNA_CHARS [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [KSIZE_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    kmer_item_t         in_data;
    logic               out_valid;
    logic               out_ready;
    kmer_result_t       out_data;

    bit          no_idle;
    int          fail_count;
    int          items_sent;
    int          results_checked;
    int          cfg_writes;
    int          query_beats;
    longint      cycle_count;

    // model state
    logic [KSIZE_W-1:0] ksize_reg;
    int unsigned        fwd_win;
    int unsigned        rev_win;
    int unsigned        run_len;
    logic [31:0]        seq_bases;
    bit [31:0]          kmer_tally [0:65535];
    kmer_result_t       pending_kmers [$];

    canonical_kmer_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("canonical_kmer_counter test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Window update and table access for one accepted base.
    task automatic predict_kmer(input kmer_item_t item);
        int unsigned  k;
        int unsigned  mask;
        int unsigned  code;
        int unsigned  canon;
        bit           good;
        bit           kvalid;
        kmer_result_t res;
        begin
            if (ksize_reg == 0)
                k = 1;
            else if (ksize_reg > MODEL_MAX_K)
                k = MODEL_MAX_K;
            else
                k = ksize_reg;
            mask = (1 << (2 * k)) - 1;
            good = 1'b1;
            case (item.base_char)
                CHAR_A:  code = CODE_A;
                CHAR_C:  code = CODE_C;
                CHAR_G:  code = CODE_G;
                CHAR_T:  code = CODE_T;
                default:
                begin
                    code = CODE_A;
                    good = 1'b0;
                end
            endcase
            if (item.seq_start)
            begin
                fwd_win   = 0;
                rev_win   = 0;
                seq_bases = '0;
                run_len   = 0;
            end
            fwd_win = ((fwd_win << 2) | code) & mask;
            rev_win = (((rev_win & mask) >> 2) | ((3 - code) << (2 * (k - 1)))) & mask;
            if (seq_bases != 32'hFFFF_FFFF)
                seq_bases++;
            if (!good)
                run_len = 0;
            else if (run_len < RUN_MAX)
                run_len++;
            kvalid = (run_len >= k);
            canon  = ((fwd_win < rev_win) ? fwd_win : rev_win) & 16'hFFFF;
            if (seq_bases < k)
                return;
            if (item.func == FUNC_COUNT)
            begin
                if (kvalid && kmer_tally[canon] != 32'hFFFF_FFFF)
                    kmer_tally[canon]++;
                return;
            end
            res.position     = seq_bases - k + 1;
            res.forward_word = fwd_win[15:0];
            res.reverse_word = rev_win[15:0];
            res.kmer_valid   = kvalid;
            res.occurrences  = kvalid ? kmer_tally[canon] : 32'd0;
            pending_kmers = {pending_kmers, res};
            query_beats++;
        end
    endtask

    always @(posedge clk)
    begin
        kmer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_kmers.size() == 0)
            begin
                $error("unexpected result beat: position %0d", out_data.position);
                fail_count++;
            end
            else
            begin
                want = pending_kmers.pop_front();
                results_checked++;
                if (out_data.position !== want.position)
                begin
                    $error("position: expected %0d actual %0d", want.position,
                           out_data.position);
                    fail_count++;
                end
                if (out_data.forward_word !== want.forward_word)
                begin
                    $error("forward_word: expected %h actual %h", want.forward_word,
                           out_data.forward_word);
                    fail_count++;
                end
                if (out_data.reverse_word !== want.reverse_word)
                begin
                    $error("reverse_word: expected %h actual %h", want.reverse_word,
                           out_data.reverse_word);
                    fail_count++;
                end
                if (out_data.kmer_valid !== want.kmer_valid)
                begin
                    $error("kmer_valid: expected %b actual %b", want.kmer_valid,
                           out_data.kmer_valid);
                    fail_count++;
                end
                if (out_data.occurrences !== want.occurrences)
                begin
                    $error("occurrences: expected %0d actual %0d", want.occurrences,
                           out_data.occurrences);
                    fail_count++;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic send_base(input kmer_item_t item);
        begin
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do
                @(posedge clk);
            while (!in_ready);
            predict_kmer(item);
            items_sent++;
        end
    endtask

    task automatic send_string(input logic f, input string bases, input bit fresh);
        kmer_item_t item;
        begin
            for (int i = 0; i < bases.len(); i++)
            begin
                item.func      = f;
                item.base_char = bases[i];
                item.seq_start = fresh && (i == 0);
                send_base(item);
            end
        end
    endtask

    // Count beats give no result, so let the table pipeline empty after the last one.
    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            while (pending_kmers.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_size(input logic [KSIZE_W-1:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            ksize_reg = value;
            cfg_writes++;
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Reset size of 8, all-T window and a window shifted past it.
    task automatic test_default_size();
        begin
            send_string(FUNC_QUERY, "TTTTTTTTA", 1'b1);
        end
    endtask

    // Size 0 behaves as 1; invalid byte gives an invalid window.
    task automatic test_size_clamp();
        kmer_item_t item;
        begin
            drain_results();
            write_size(4'd0);
            send_string(FUNC_COUNT, "AT", 1'b1);
            send_string(FUNC_QUERY, "C", 1'b1);
            item.func      = FUNC_QUERY;
            item.base_char = 8'h00;
            item.seq_start = 1'b0;
            send_base(item);
            send_string(FUNC_QUERY, "GA", 1'b0);
        end
    endtask

    // Size above the maximum, then a size cut in the middle of a sequence.
    task automatic test_size_change();
        kmer_item_t item;
        begin
            drain_results();
            write_size(4'd15);
            send_string(FUNC_QUERY, "ACGTACG", 1'b1);
            item.func      = FUNC_QUERY;
            item.base_char = 8'hFF;
            item.seq_start = 1'b0;
            send_base(item);
            drain_results();
            write_size(4'd3);
            send_string(FUNC_QUERY, "AT", 1'b0);
        end
    endtask

    // Mostly well-formed strands counted then queried, with noise mixed in.
    task automatic run_stream_phase(input int budget);
        logic [7:0] strand [STRAND_MAX];
        int         stop_at;
        int         len;
        int         passes;
        bit         resume;
        kmer_item_t item;
        begin
            stop_at = items_sent + budget;
            while (items_sent < stop_at)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 16);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < 8)
                        strand[i] = 8'($urandom_range(0, 255));
                    else
                        strand[i] = DNA_CHARS[$urandom_range(0, 3)];
                end
                resume = ($urandom_range(0, 9) == 0);
                passes = $urandom_range(0, 2);
                for (int p = 0; p <= passes; p++)
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        item.func      = (p == passes) ? FUNC_QUERY : FUNC_COUNT;
                        item.base_char = strand[i];
                        item.seq_start = (i == 0) && !resume;
                        if ($urandom_range(0, 99) < 10)
                        begin
                            item.func      = 1'($urandom_range(0, 1));
                            item.seq_start = 1'($urandom_range(0, 1));
                        end
                        send_base(item);
                    end
                end
                if ($urandom_range(0, 99) < 3)
                    drain_results();
            end
        end
    endtask

    task automatic test_random_streams();
        logic [KSIZE_W-1:0] size;
        begin
            for (int phase = 0; phase < 14; phase++)
            begin
                drain_results();
                if (phase == 0)
                    size = 4'd1;
                else if (phase == 1)
                    size = 4'd8;
                else if ($urandom_range(0, 1) == 0)
                    size = 4'($urandom_range(1, 4));
                else
                    size = 4'($urandom_range(0, 15));
                write_size(size);
                no_idle = (phase == 6);
                run_stream_phase((phase == 6) ? 150 : 75);
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        no_idle     = 1'b0;
        ksize_reg   = KSIZE_RESET;
        fwd_win     = 0;
        rev_win     = 0;
        run_len     = 0;
        seq_bases   = '0;
        fail_count  = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_default_size();
        test_size_clamp();
        test_size_change();
        test_random_streams();
        drain_results();

        $display("Sent %0d bases (%0d query windows) over %0d size settings.",
                 items_sent, query_beats, cfg_writes);
        $display("Checked %0d result beats, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0)
            $display("canonical_kmer_counter test passed");
        else
            $display("canonical_kmer_counter test failed");
        $finish;
    end

endmodule
